// ===== hw/rtl/rap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rap_pkg: shared types and constants for the IEEE round-and-pack pipeline
// Stage records, format constants, class and rounding direction codes.
// ----------------------------------------------------------------------------
package rap_pkg;

  localparam int SigW = 128;

  // Value classes.
  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_INF  = 2'd1;
  localparam logic [1:0] CLS_NAN  = 2'd2;
  localparam logic [1:0] CLS_FIN  = 2'd3;

  // Rounding directions.
  localparam logic [1:0] RND_NEAR = 2'd0;
  localparam logic [1:0] RND_ZERO = 2'd1;
  localparam logic [1:0] RND_POS  = 2'd2;
  localparam logic [1:0] RND_NEG  = 2'd3;

  // Register addresses (register index taken from paddr[2]).
  localparam logic ADDR_DIR = 1'b0;

  // Format constants.
  localparam logic signed [17:0] SGL_BIAS = 18'sd127;
  localparam logic signed [17:0] DBL_BIAS = 18'sd1023;
  localparam logic signed [17:0] SGL_EMAX = 18'sd255;
  localparam logic signed [17:0] DBL_EMAX = 18'sd2047;
  // Right shift that leaves fraction bits plus the hidden bit in a normal value.
  localparam logic [17:0] SGL_RBASE = 18'd104;
  localparam logic [17:0] DBL_RBASE = 18'd75;
  localparam logic [7:0]  R_MAX     = 8'd129;

  typedef struct packed {
    logic               dbl;
    logic               sgn;
    logic [1:0]         cls;
    logic [1:0]         dir;
    logic signed [17:0] e;
    logic               tiny;
    logic [7:0]         r;
    logic [SigW-1:0]    sig;
    logic               stin;
  } rap_s1_t;

  typedef struct packed {
    logic               dbl;
    logic               sgn;
    logic [1:0]         cls;
    logic [1:0]         dir;
    logic signed [17:0] e;
    logic               tiny;
    logic [53:0]        kept;
    logic               rb;
    logic               st;
    logic               inx;
    logic               inc;
    logic [51:0]        nan_frac;
  } rap_s2_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rap_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rap_prep: first stage, biased exponent and denormalizing shift
// Adds the bias, flags tiny values and works out the total right shift.
// ----------------------------------------------------------------------------
module rap_prep (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                dbl,
  input  wire logic                sgn,
  input  wire logic [1:0]          cls,
  input  wire logic [1:0]          dir,
  input  wire logic signed [15:0]  expo,
  input  wire logic [127:0]        sig,
  input  wire logic                stin,
  output logic                     s1_valid,
  output rap_pkg::rap_s1_t         s1
);
  import rap_pkg::*;

  logic signed [17:0] e_c;
  logic               tiny_c;
  logic [17:0]        diff_c;
  logic [7:0]         r_c;

  always_comb begin
    e_c    = 18'(expo) + (dbl ? DBL_BIAS : SGL_BIAS);
    tiny_c = (e_c <= 18'sd0);
    // Shift for tiny values grows by 1 - e; it saturates past the significand.
    diff_c = (dbl ? DBL_RBASE : SGL_RBASE) + (tiny_c ? 18'(18'sd1 - e_c) : 18'd0);
    r_c    = (diff_c > 18'(R_MAX)) ? R_MAX : diff_c[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1.dbl  <= dbl;
    s1.sgn  <= sgn;
    s1.cls  <= cls;
    s1.dir  <= dir;
    s1.e    <= e_c;
    s1.tiny <= tiny_c;
    s1.r    <= r_c;
    s1.sig  <= sig;
    s1.stin <= stin;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rap_align.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rap_align: second stage, alignment and rounding decision
// Extracts the kept bits, round bit and sticky bit and decides the increment.
// ----------------------------------------------------------------------------
module rap_align (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s1_valid,
  input  rap_pkg::rap_s1_t s1,
  output logic             s2_valid,
  output rap_pkg::rap_s2_t s2
);
  import rap_pkg::*;

  logic [SigW-1:0] kept_w;
  logic [SigW-1:0] rb_w;
  logic [SigW-1:0] lo_w;
  logic            rb_c;
  logic            st_c;
  logic            inx_c;
  logic            inc_c;
  logic [51:0]     nan_c;

  always_comb begin
    kept_w = s1.sig >> s1.r;
    rb_w   = s1.sig >> (s1.r - 8'd1);
    rb_c   = rb_w[0];
    // Bits below the round bit survive a left shift by 129 - r.
    lo_w   = s1.sig << (R_MAX - s1.r);
    st_c   = (lo_w != '0) || s1.stin;
    inx_c  = rb_c || st_c;
    case (s1.dir)
      RND_NEAR: inc_c = rb_c;
      RND_ZERO: inc_c = 1'b0;
      RND_POS:  inc_c = !s1.sgn && inx_c;
      RND_NEG:  inc_c = s1.sgn && inx_c;
      default:  inc_c = 1'b0;
    endcase
    if (s1.dbl) begin
      nan_c = {1'b1, s1.sig[125:75]};
    end else begin
      nan_c = {29'd0, 1'b1, s1.sig[125:104]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2.dbl      <= s1.dbl;
    s2.sgn      <= s1.sgn;
    s2.cls      <= s1.cls;
    s2.dir      <= s1.dir;
    s2.e        <= s1.e;
    s2.tiny     <= s1.tiny;
    s2.kept     <= kept_w[53:0];
    s2.rb       <= rb_c;
    s2.st       <= st_c;
    s2.inx      <= inx_c;
    s2.inc      <= inc_c;
    s2.nan_frac <= nan_c;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rap_pack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rap_pack: third stage, increment, range checks and packing
// Applies the increment, handles carries, overflow and underflow, packs.
// ----------------------------------------------------------------------------
module rap_pack (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s2_valid,
  input  rap_pkg::rap_s2_t s2,
  output logic             done,
  output logic [63:0]      packed_value,
  output logic             inexact_flag,
  output logic             underflow_flag,
  output logic             overflow_flag
);
  import rap_pkg::*;

  logic [53:0]        sum_c;
  logic               carry_n;
  logic               carry_t;
  logic signed [17:0] e_c;
  logic signed [17:0] emax_c;
  logic [51:0]        fmask_c;
  logic [10:0]        expf_c;
  logic [51:0]        frac_c;
  logic               inx_c;
  logic               unf_c;
  logic               ovf_c;
  logic               to_inf;
  logic [63:0]        word_c;

  always_comb begin
    sum_c = s2.kept + 54'(s2.inc);
    if (s2.dir == RND_NEAR && s2.rb && !s2.st) begin
      sum_c[0] = 1'b0;
    end
    carry_n = s2.dbl ? sum_c[53] : sum_c[24];
    carry_t = s2.dbl ? sum_c[52] : sum_c[23];
    emax_c  = s2.dbl ? DBL_EMAX : SGL_EMAX;
    fmask_c = s2.dbl ? {52{1'b1}} : {29'd0, {23{1'b1}}};
    e_c     = s2.e + 18'(carry_n);
    inx_c   = 1'b0;
    unf_c   = 1'b0;
    ovf_c   = 1'b0;
    to_inf  = 1'b0;
    expf_c  = '0;
    frac_c  = '0;
    case (s2.cls)
      CLS_ZERO: begin
        expf_c = '0;
      end
      CLS_INF: begin
        to_inf = 1'b1;
      end
      CLS_NAN: begin
        expf_c = emax_c[10:0];
        frac_c = s2.nan_frac;
      end
      default: begin
        inx_c = s2.inx;
        if (s2.tiny) begin
          if (carry_t) begin
            expf_c = 11'd1;
            unf_c  = 1'b1;
          end else begin
            unf_c  = s2.inx;
            frac_c = sum_c[51:0] & fmask_c;
          end
        end else if (e_c >= emax_c) begin
          ovf_c = 1'b1;
          inx_c = 1'b1;
          if (s2.dir == RND_NEAR || (s2.dir == RND_POS && !s2.sgn) ||
              (s2.dir == RND_NEG && s2.sgn)) begin
            to_inf = 1'b1;
          end else begin
            expf_c = 11'(emax_c - 18'sd1);
            frac_c = fmask_c;
          end
        end else begin
          expf_c = e_c[10:0];
          frac_c = carry_n ? 52'd0 : (sum_c[51:0] & fmask_c);
        end
      end
    endcase
    if (to_inf) begin
      expf_c = emax_c[10:0];
      frac_c = '0;
    end
    if (s2.dbl) begin
      word_c = {s2.sgn, expf_c, frac_c};
    end else begin
      word_c = {32'd0, s2.sgn, expf_c[7:0], frac_c[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    packed_value   <= word_c;
    inexact_flag   <= inx_c;
    underflow_flag <= unf_c;
    overflow_flag  <= ovf_c;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ieee_round_and_pack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ieee_round_and_pack: rounds an unpacked value and packs it to IEEE format
// Three-stage pipeline producing a single or double word plus flags.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                      Payload
//   ------    ---------------------------    ---------------------------------
//   input     start & !busy                  mode, sign, value_class, exponent,
//                                            sig_high, sig_low, sig_sticky
//   result    done (one-cycle strobe)        packed_value, inexact_flag,
//                                            underflow_flag, overflow_flag
//   config    APB write, psel&penable&pwrite round_direction at address 0
//
// A new beat can be accepted every cycle: the three register stages
// (exponent prep, alignment shifts, increment and pack) each hold one beat,
// and the result strobe is registered in the last stage with the result.
// busy is never raised, because the receiver cannot hold results off and the
// pipeline therefore never stalls.
// Synchronous reset clears the stage valid bits and sets the rounding
// direction to nearest even; payload registers are not reset.
// The rounding direction should only be written while no beat is in flight.
//
module ieee_round_and_pack (
  input  wire logic               clk,
  input  wire logic               rst,
  // Command interface.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic               sign,
  input  wire logic [1:0]         value_class,
  input  wire logic signed [15:0] exponent,
  input  wire logic [63:0]        sig_high,
  input  wire logic [63:0]        sig_low,
  input  wire logic               sig_sticky,
  // Results.
  output logic                    done,
  output logic [63:0]             packed_value,
  output logic                    inexact_flag,
  output logic                    underflow_flag,
  output logic                    overflow_flag,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rap_pkg::*;

  logic             round_direction;
  logic [1:0]       dir;
  logic             accept;
  logic             s1_valid;
  rap_s1_t          s1;
  logic             s2_valid;
  rap_s2_t          s2;

  // The pipeline never backs up, so it is always ready for a new beat.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // Register index is paddr[2]; only index zero exists.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= RND_NEAR;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_DIR) begin
      dir <= pwdata[1:0];
    end
  end

  assign round_direction = (paddr[2] == ADDR_DIR);
  assign prdata = round_direction ? {30'd0, dir} : 32'd0;

  rap_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .dbl      (mode),
    .sgn      (sign),
    .cls      (value_class),
    .dir      (dir),
    .expo     (exponent),
    .sig      ({sig_high, sig_low}),
    .stin     (sig_sticky),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  rap_align u_align (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  rap_pack u_pack (
    .clk            (clk),
    .rst            (rst),
    .s2_valid       (s2_valid),
    .s2             (s2),
    .done           (done),
    .packed_value   (packed_value),
    .inexact_flag   (inexact_flag),
    .underflow_flag (underflow_flag),
    .overflow_flag  (overflow_flag)
  );

  // A result strobe always traces back to an accepted beat.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without a matching accepted beat");

  // Overflow always implies an inexact result.
  a_ovf_inexact: assert property (@(posedge clk) disable iff (rst)
    (done && overflow_flag) |-> inexact_flag)
    else $error("overflow reported without inexact");

  // A value cannot both overflow and underflow.
  a_ovf_unf: assert property (@(posedge clk) disable iff (rst)
    done |-> !(overflow_flag && underflow_flag))
    else $error("overflow and underflow both reported");

  // Single precision results leave the upper word clear.
  a_single_upper: assert property (@(posedge clk) disable iff (rst)
    (accept && !mode) |-> ##3 (packed_value[63:32] == 32'd0))
    else $error("single precision result with upper bits set");

endmodule
`default_nettype wire
